// ===== hdl/sierpinski_triangle_subdivider_unit_defines.svh =====
`ifndef SIERPINSKI_TRIANGLE_SUBDIVIDER_UNIT_DEFINES_SVH
`define SIERPINSKI_TRIANGLE_SUBDIVIDER_UNIT_DEFINES_SVH

// Checks that a condition implies another condition in the same cycle.
`define STS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies another condition in the following cycle.
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sts_pkg.sv =====
package sts_pkg;

    localparam int COORD_W   = 16;
    localparam int MAX_DEPTH = 3;
    localparam int DEPTH_W   = 2;
    localparam int LVL_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    localparam logic [1:0] CHILD_A = 2'd0;
    localparam logic [1:0] CHILD_C = 2'd1;
    localparam logic [1:0] CHILD_B = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    // x sits in the lowest bits, so a packed triangle matches the tdata layout.
    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vec3_t;

    typedef struct packed {
        vec3_t c;
        vec3_t b;
        vec3_t a;
    } tri_t;

    typedef logic [MAX_DEPTH-1:0][1:0] path_t;

    typedef struct packed {
        tri_t               shape;
        path_t              path;
        logic [DEPTH_W-1:0] depth;
        logic               last;
    } item_t;

    // Floor of the half sum, taken from the exact 17-bit sum.
    function automatic coord_t midpoint(input coord_t p, input coord_t q);
        logic signed [COORD_W:0] sum;
        begin
            sum = {p[COORD_W-1], p} + {q[COORD_W-1], q};
            return sum[COORD_W:1];
        end
    endfunction

    function automatic vec3_t mid3(input vec3_t p, input vec3_t q);
        vec3_t r;
        begin
            r.x = midpoint(p.x, q.x);
            r.y = midpoint(p.y, q.y);
            r.z = midpoint(p.z, q.z);
            return r;
        end
    endfunction

    function automatic tri_t child(input tri_t t, input logic [1:0] sel);
        vec3_t ab;
        vec3_t ac;
        vec3_t bc;
        tri_t  r;
        begin
            ab = mid3(t.a, t.b);
            ac = mid3(t.a, t.c);
            bc = mid3(t.b, t.c);
            case (sel)
                CHILD_A: r = '{c: ac, b: ab, a: t.a};
                CHILD_C: r = '{c: bc, b: ac, a: t.c};
                CHILD_B: r = '{c: ab, b: bc, a: t.b};
                default: r = '{c: ab, b: bc, a: t.b};
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hdl/sts_issue.sv =====
module sts_issue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [sts_pkg::DEPTH_W-1:0]  depth,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  sts_pkg::tri_t                in_tri,
    output logic                         out_valid,
    input  logic                         out_ready,
    output sts_pkg::item_t               out_item
);

    logic                        busy_reg;
    logic                        busy_next;
    sts_pkg::tri_t               tri_reg;
    logic [sts_pkg::DEPTH_W-1:0] depth_reg;
    sts_pkg::path_t              path_reg;
    sts_pkg::path_t              path_next;
    sts_pkg::path_t              path_inc;
    logic                        last;
    logic                        carry;
    logic                        in_fire;
    logic                        out_fire;

    // The path is a base-3 counter over the active levels; the deepest active
    // level changes fastest, which gives the depth-first order.
    always_comb
    begin
        last     = 1'b1;
        carry    = 1'b1;
        path_inc = path_reg;
        for (int i = sts_pkg::MAX_DEPTH - 1; i >= 0; i--)
        begin
            if (int'(depth_reg) > i)
            begin
                if (path_reg[i] != sts_pkg::CHILD_B)
                begin
                    last = 1'b0;
                end
                if (carry)
                begin
                    if (path_reg[i] == sts_pkg::CHILD_B)
                    begin
                        path_inc[i] = sts_pkg::CHILD_A;
                    end
                    else
                    begin
                        path_inc[i] = path_reg[i] + 2'd1;
                        carry       = 1'b0;
                    end
                end
            end
        end
    end

    assign out_valid = busy_reg;
    assign out_fire  = busy_reg && out_ready;
    assign in_ready  = !busy_reg || (last && out_ready);
    assign in_fire   = in_valid && in_ready;

    assign out_item.shape = tri_reg;
    assign out_item.path  = path_reg;
    assign out_item.depth = depth_reg;
    assign out_item.last  = last;

    always_comb
    begin
        busy_next = busy_reg;
        path_next = path_reg;
        if (in_fire)
        begin
            busy_next = 1'b1;
            path_next = '0;
        end
        else if (out_fire)
        begin
            busy_next = !last;
            path_next = path_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        path_reg <= path_next;
        if (in_fire)
        begin
            tri_reg   <= in_tri;
            depth_reg <= depth;
        end
    end

endmodule

// ===== hdl/sts_level.sv =====
module sts_level (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [sts_pkg::LVL_W-1:0]   level,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sts_pkg::item_t              in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output sts_pkg::item_t              out_item
);

    logic           valid_reg;
    sts_pkg::item_t item_reg;
    sts_pkg::item_t item_next;

    // Levels beyond the item's depth pass the triangle through untouched.
    always_comb
    begin
        item_next = in_item;
        if (int'(in_item.depth) > int'(level))
        begin
            item_next.shape = sts_pkg::child(in_item.shape, in_item.path[level]);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== hdl/sierpinski_triangle_subdivider_unit.sv =====
// Splits each input triangle by edge midpoints subdivision_depth times (0 to 3)
// and sends out the 3^depth corner triangles in depth-first order, one
// triangle per output transfer, with tlast on the final one. An input triangle
// occupies the issue stage until its final path is taken; the issue counter
// emits one path per cycle unless the output stalls, so output transfers run
// at one per cycle back to back across input triangles. Each path passes
// through one register stage per subdivision level up to the maximum depth,
// and the last one drives the output. Depth is sampled when the input transfer happens;
// change it only while the block is idle.
`include "sierpinski_triangle_subdivider_unit_defines.svh"

module sierpinski_triangle_subdivider_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sts_pkg::DEPTH_W-1:0]         cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
    // vertex_c_x, vertex_c_y, vertex_c_z
    input  logic [9*sts_pkg::COORD_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
    // out_c_x, out_c_y, out_c_z
    output logic [9*sts_pkg::COORD_W-1:0]       m_tdata,
    output logic                                m_tlast
);

    logic [sts_pkg::DEPTH_W-1:0] depth_reg;

    logic           stg_valid [sts_pkg::MAX_DEPTH+1];
    logic           stg_ready [sts_pkg::MAX_DEPTH+1];
    sts_pkg::item_t stg_item  [sts_pkg::MAX_DEPTH+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            depth_reg <= cfg_data;
        end
    end

    sts_issue u_issue (
        .clk       (clk),
        .rst_n     (rst_n),
        .depth     (depth_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_tri    (sts_pkg::tri_t'(s_tdata)),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_item  (stg_item[0])
    );

    for (genvar i = 0; i < sts_pkg::MAX_DEPTH; i++)
    begin : g_level
        sts_level u_level (
            .clk       (clk),
            .rst_n     (rst_n),
            .level     (sts_pkg::LVL_W'(i)),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_item   (stg_item[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_item  (stg_item[i+1])
        );
    end

    assign m_tvalid = stg_valid[sts_pkg::MAX_DEPTH];
    assign stg_ready[sts_pkg::MAX_DEPTH] = m_tready;
    assign m_tdata  = stg_item[sts_pkg::MAX_DEPTH].shape;
    assign m_tlast  = stg_item[sts_pkg::MAX_DEPTH].last;

    // An unsubdivided triangle is always the final one of its input.
    `STS_ASSERT_SAME(a_depth0_last,
        m_tvalid && (stg_item[sts_pkg::MAX_DEPTH].depth == '0),
        m_tlast, "depth zero triangle without tlast")

    // An accepted input always starts issuing in the next cycle.
    `STS_ASSERT_NEXT(a_issue_starts, s_tvalid && s_tready, stg_valid[0],
        "issue stage idle after input transfer")

    // After the final path leaves, the issue stage is idle unless a new input arrived.
    `STS_ASSERT_NEXT(a_issue_ends,
        stg_valid[0] && stg_ready[0] && stg_item[0].last && !s_tvalid,
        !stg_valid[0], "issue stage busy after final path")

endmodule
